[design/gda_pkg.sv]
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, calendar constants and helpers for the date arithmetic core.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

   localparam int YEAR_W = 14;
   localparam int MON_W  = 4;
   localparam int DAY_W  = 5;
   localparam int DIST_W = 22;
   localparam int DOY_W  = 9;

   localparam int MAX_YEAR_DEF    = 9999;
   localparam int OFFSET_BITS_DEF = 21;

   localparam int MONTHS     = 12;
   localparam int DAYS_YEAR  = 365;
   localparam int DAYS_4Y    = 1461;
   localparam int DAYS_100Y  = 36524;
   localparam int DAYS_400Y  = 146097;
   localparam int LAST_QUAD  = 24;   // four-year group holding the century year
   localparam int DIST_MAX   = (1 << DIST_W) - 1;

   // distance and compare results riding beside the serial-to-date stages
   typedef struct packed {
      logic              first_greater;
      logic              dates_equal;
      logic [DIST_W-1:0] day_distance;
      logic              range_error;
   } side_type;

   function automatic int yc_bits(input int max_year);
      return $clog2(max_year + 1);
   endfunction

   function automatic int ser_bits(input int max_year);
      return $clog2(366 * max_year + 32);
   endfunction

   // days in the year before the first of the month (non-leap)
   function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] month);
      logic [DOY_W-1:0] d;
      unique case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] month,
                                                    input logic leap);
      logic [DOY_W-1:0] adj;
      adj = (leap && month > MON_W'(2)) ? DOY_W'(1) : DOY_W'(0);
      return days_before(month) + adj;
   endfunction

endpackage

`default_nettype wire

[design/gda_serial.sv]
// ----------------------------------------------------------------------------
// gda_serial
// Two-stage date to serial day number (0001-01-01 is day 1).
// ----------------------------------------------------------------------------
`default_nettype none

module gda_serial
   import gda_pkg::*;
#(
   parameter int MAX_YEAR = MAX_YEAR_DEF
) (
   input  wire logic                 clock,
   input  wire logic [1:0]           stage_en,
   input  wire logic [YEAR_W-1:0]    year,
   input  wire logic [MON_W-1:0]     month,
   input  wire logic [DAY_W-1:0]     day,
   output logic [ser_bits(MAX_YEAR)-1:0] serial
);

   localparam int  YC_W  = yc_bits(MAX_YEAR);
   localparam int  SER_W = ser_bits(MAX_YEAR);
   localparam int  PR_W  = 2 * YC_W + 1;
   localparam int  K100  = YC_W + 7;
   localparam longint M100 = ((longint'(1) << K100) + 99) / 100;

   logic [YC_W-1:0]  yy_in, yy_ff, q_in, q_ff;
   logic [MON_W-1:0] mm_in, mm_ff;
   logic [DAY_W-1:0] day_ff;
   logic [PR_W-1:0]  prod;
   logic [SER_W-1:0] ser_in, ser_ff;

   // stage 1: clamp, year / 100 by reciprocal
   always_comb begin
      if (year == '0) begin
         yy_in = YC_W'(1);
      end else if (32'(year) > 32'(MAX_YEAR)) begin
         yy_in = YC_W'(MAX_YEAR);
      end else begin
         yy_in = YC_W'(year);
      end
      if (month == '0) begin
         mm_in = MON_W'(1);
      end else if (month > MON_W'(MONTHS)) begin
         mm_in = MON_W'(MONTHS);
      end else begin
         mm_in = month;
      end
      prod = PR_W'(yy_in) * PR_W'(M100);
      q_in = YC_W'(prod >> K100);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         yy_ff  <= yy_in;
         q_ff   <= q_in;
         mm_ff  <= mm_in;
         day_ff <= day;
      end
   end

   // stage 2: 365*p + p/4 - p/100 + p/400 + month offset + day
   always_comb begin
      logic            cent;
      logic            leap;
      logic [YC_W-1:0] p, qp;
      cent = (yy_ff == YC_W'(q_ff * YC_W'(100)));
      p    = yy_ff - YC_W'(1);
      qp   = cent ? q_ff - YC_W'(1) : q_ff;
      leap = (yy_ff[1:0] == 2'b00) && (!cent || q_ff[1:0] == 2'b00);
      ser_in = SER_W'(DAYS_YEAR) * SER_W'(p) + SER_W'(p >> 2) - SER_W'(qp)
             + SER_W'(qp >> 2) + SER_W'(month_start(mm_ff, leap)) + SER_W'(day_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         ser_ff <= ser_in;
      end
   end

   assign serial = ser_ff;

endmodule

`default_nettype wire

[design/gda_split.sv]
// ----------------------------------------------------------------------------
// gda_split
// Six-stage serial day index (0-based) back to year, month and day.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_split
   import gda_pkg::*;
#(
   parameter int MAX_YEAR = MAX_YEAR_DEF
) (
   input  wire logic                          clock,
   input  wire logic [5:0]                    stage_en,
   input  wire logic [ser_bits(MAX_YEAR)-1:0] day_index,
   output logic [yc_bits(MAX_YEAR)-1:0]       year,
   output logic [MON_W-1:0]                   month,
   output logic [DAY_W-1:0]                   day
);

   localparam int  YC_W   = yc_bits(MAX_YEAR);
   localparam int  SER_W  = ser_bits(MAX_YEAR);
   localparam int  Q400_W = $clog2(MAX_YEAR / 400 + 1);
   localparam int  PR_W   = 2 * SER_W + 1;
   localparam int  K400   = SER_W + 18;
   localparam longint M400 = ((longint'(1) << K400) + DAYS_400Y - 1) / DAYS_400Y;
   localparam int  R400_W = 18;
   localparam int  R100_W = 16;
   localparam int  K1461  = R100_W + 11;
   localparam longint M1461 = ((longint'(1) << K1461) + DAYS_4Y - 1) / DAYS_4Y;
   localparam int  P1_W   = 2 * R100_W + 1;
   localparam int  R4_W   = 11;
   localparam int  Q4_W   = 5;

   // stage A: quotient by 400-year cycle
   logic [SER_W-1:0]  n_ff;
   logic [Q400_W-1:0] q400_ff;
   logic [PR_W-1:0]   prod400;

   assign prod400 = PR_W'(day_index) * PR_W'(M400);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         n_ff    <= day_index;
         q400_ff <= Q400_W'(prod400 >> K400);
      end
   end

   // stage B: remainder within the cycle
   logic [R400_W-1:0] r400_ff;
   logic [YC_W-1:0]   y400_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         r400_ff <= R400_W'(n_ff - SER_W'(q400_ff) * SER_W'(DAYS_400Y));
         y400_ff <= YC_W'(q400_ff) * YC_W'(400);
      end
   end

   // stage C: century, the last one takes the extra day
   logic [1:0]        q100;
   logic [R100_W-1:0] r100_ff;
   logic [YC_W-1:0]   y100_ff;
   logic              cent3_ff;

   always_comb begin
      if (r400_ff >= R400_W'(3 * DAYS_100Y)) begin
         q100 = 2'd3;
      end else if (r400_ff >= R400_W'(2 * DAYS_100Y)) begin
         q100 = 2'd2;
      end else if (r400_ff >= R400_W'(DAYS_100Y)) begin
         q100 = 2'd1;
      end else begin
         q100 = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         r100_ff  <= R100_W'(r400_ff - R400_W'(q100) * R400_W'(DAYS_100Y));
         y100_ff  <= y400_ff + YC_W'(q100) * YC_W'(100);
         cent3_ff <= (q100 == 2'd3);
      end
   end

   // stage D: four-year group by reciprocal
   logic [P1_W-1:0]   prod1461;
   logic [Q4_W-1:0]   q4_ff;
   logic [R100_W-1:0] r100d_ff;
   logic [YC_W-1:0]   y100d_ff;
   logic              cent3d_ff;

   assign prod1461 = P1_W'(r100_ff) * P1_W'(M1461);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         q4_ff     <= Q4_W'(prod1461 >> K1461);
         r100d_ff  <= r100_ff;
         y100d_ff  <= y100_ff;
         cent3d_ff <= cent3_ff;
      end
   end

   // stage E: year inside the group, day of year, leap flag
   logic [R4_W-1:0]  r4;
   logic [1:0]       q1;
   logic [DOY_W-1:0] r1_ff;
   logic [YC_W-1:0]  year_e_ff;
   logic             leap_ff;

   always_comb begin
      r4 = R4_W'(r100d_ff - R100_W'(q4_ff) * R100_W'(DAYS_4Y));
      if (r4 >= R4_W'(3 * DAYS_YEAR)) begin
         q1 = 2'd3;
      end else if (r4 >= R4_W'(2 * DAYS_YEAR)) begin
         q1 = 2'd2;
      end else if (r4 >= R4_W'(DAYS_YEAR)) begin
         q1 = 2'd1;
      end else begin
         q1 = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         r1_ff     <= DOY_W'(r4 - R4_W'(q1) * R4_W'(DAYS_YEAR));
         year_e_ff <= y100d_ff + YC_W'({q4_ff, 2'b00}) + YC_W'(q1) + YC_W'(1);
         // century year of a group is leap only in the fourth century
         leap_ff   <= (q1 == 2'd3) && (q4_ff != Q4_W'(LAST_QUAD) || cent3d_ff);
      end
   end

   // stage F: month search over the start table
   logic [MON_W-1:0] mon;
   logic [YC_W-1:0]  year_ff;
   logic [MON_W-1:0] mon_ff;
   logic [DAY_W-1:0] day_ff;

   always_comb begin
      mon = MON_W'(1);
      for (int k = 2; k <= MONTHS; k++) begin
         if (r1_ff >= month_start(MON_W'(k), leap_ff)) begin
            mon = MON_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         year_ff <= year_e_ff;
         mon_ff  <= mon;
         day_ff  <= DAY_W'(r1_ff - month_start(mon, leap_ff) + DOY_W'(1));
      end
   end

   assign year  = year_ff;
   assign month = mon_ff;
   assign day   = day_ff;

endmodule

`default_nettype wire

[design/gregorian_date_arithmetic_core.sv]
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core
// Date plus signed offset, day distance and compare of two Gregorian dates.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer per cycle in, one result per cycle out. The
// pipeline has nine register stages: two for the date to serial day number
// conversion (both dates in parallel), one for the offset add, saturation,
// distance and compare, and six for the serial to date conversion (400-year,
// century, four-year and year quotients, then the month search). Back
// pressure on rsp_tready stalls only the stages that are full; bubbles close
// up. Out-of-range years and months are clamped, overlong days roll into the
// next month, and a shifted date outside 0001-01-01 .. MAX_YEAR-12-31 is
// saturated with range_error set.
`default_nettype none

module gregorian_date_arithmetic_core
   import gda_pkg::*;
#(
   parameter  int MAX_YEAR    = MAX_YEAR_DEF,
   parameter  int OFFSET_BITS = OFFSET_BITS_DEF,
   localparam int REQ_W       = ((2 * (YEAR_W + MON_W + DAY_W) + OFFSET_BITS + 7) / 8) * 8,
   localparam int RSP_W       = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // base_year, base_month, base_day, day_offset, other_year, other_month,
   // other_day, zero fill
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // shifted_year, shifted_month, shifted_day, range_error, day_distance,
   // dates_equal, first_greater
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int NS     = 9;
   localparam int SIDE_N = NS - 2;
   localparam int DATE_W = YEAR_W + MON_W + DAY_W;
   localparam int OFF_LO = DATE_W;
   localparam int OTH_LO = DATE_W + OFFSET_BITS;
   localparam int YC_W   = yc_bits(MAX_YEAR);
   localparam int SER_W  = ser_bits(MAX_YEAR);
   localparam int SUM_W  = ((SER_W > OFFSET_BITS) ? SER_W : OFFSET_BITS) + 2;
   localparam int DW     = (SER_W > DIST_W) ? SER_W : DIST_W;
   localparam int LEAP_MAX = (((MAX_YEAR % 4) == 0) && ((MAX_YEAR % 100) != 0))
                             || ((MAX_YEAR % 400) == 0);
   localparam int SMAX   = 365 * MAX_YEAR + (MAX_YEAR - 1) / 4 - (MAX_YEAR - 1) / 100
                           + (MAX_YEAR - 1) / 400 + LEAP_MAX;

   // pipeline flow control
   logic [NS-1:0] vld_ff, vld_in, en;
   logic [NS:0]   rdy;

   always_comb begin
      rdy[NS] = rsp_tready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      en        = rdy[NS-1:0];
      vld_in[0] = req_tvalid;
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NS-1];

   // date to serial, both dates
   logic [SER_W-1:0] ser_a, ser_b;

   gda_serial #(.MAX_YEAR(MAX_YEAR)) u_serial_a (
      .clock    (clock),
      .stage_en (en[1:0]),
      .year     (req_tdata[YEAR_W-1:0]),
      .month    (req_tdata[YEAR_W+MON_W-1:YEAR_W]),
      .day      (req_tdata[DATE_W-1:YEAR_W+MON_W]),
      .serial   (ser_a)
   );

   gda_serial #(.MAX_YEAR(MAX_YEAR)) u_serial_b (
      .clock    (clock),
      .stage_en (en[1:0]),
      .year     (req_tdata[OTH_LO+YEAR_W-1:OTH_LO]),
      .month    (req_tdata[OTH_LO+YEAR_W+MON_W-1:OTH_LO+YEAR_W]),
      .day      (req_tdata[OTH_LO+DATE_W-1:OTH_LO+YEAR_W+MON_W]),
      .serial   (ser_b)
   );

   logic [OFFSET_BITS-1:0] off1_ff, off2_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         off1_ff <= req_tdata[OFF_LO+OFFSET_BITS-1:OFF_LO];
      end
      if (en[1]) begin
         off2_ff <= off1_ff;
      end
   end

   // shift, saturate, distance, compare
   logic [SER_W-1:0] idx_in, idx_ff;
   side_type         side_in;
   side_type         side_ff [SIDE_N];

   always_comb begin
      logic signed [SUM_W-1:0] sh;
      logic [DW-1:0]           dd;
      sh = $signed(SUM_W'(ser_a)) + SUM_W'($signed(off2_ff));
      side_in.range_error = 1'b1;
      if (sh < $signed(SUM_W'(1))) begin
         idx_in = '0;
      end else if (sh > $signed(SUM_W'(SMAX))) begin
         idx_in = SER_W'(SMAX - 1);
      end else begin
         idx_in              = SER_W'(sh - $signed(SUM_W'(1)));
         side_in.range_error = 1'b0;
      end
      dd = (ser_a >= ser_b) ? DW'(ser_a - ser_b) : DW'(ser_b - ser_a);
      side_in.day_distance  = (dd > DW'(DIST_MAX)) ? '1 : DIST_W'(dd);
      side_in.dates_equal   = (ser_a == ser_b);
      side_in.first_greater = (ser_a > ser_b);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         idx_ff     <= idx_in;
         side_ff[0] <= side_in;
      end
      for (int k = 1; k < SIDE_N; k++) begin
         if (en[2+k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // serial back to date
   logic [YC_W-1:0]  sh_year;
   logic [MON_W-1:0] sh_month;
   logic [DAY_W-1:0] sh_day;

   gda_split #(.MAX_YEAR(MAX_YEAR)) u_split (
      .clock     (clock),
      .stage_en  (en[NS-1:3]),
      .day_index (idx_ff),
      .year      (sh_year),
      .month     (sh_month),
      .day       (sh_day)
   );

   assign rsp_tdata = {side_ff[SIDE_N-1].first_greater,
                       side_ff[SIDE_N-1].dates_equal,
                       side_ff[SIDE_N-1].day_distance,
                       side_ff[SIDE_N-1].range_error,
                       sh_day, sh_month, YEAR_W'(sh_year)};

endmodule

`default_nettype wire
